>>> rtl/lkvc_pkg.sv
`timescale 1ns / 1ps
package lkvc_pkg;

   localparam int ENTRIES   = 16;
   localparam int KEY_BITS  = 32;
   localparam int DATA_BITS = 32;

   localparam int RANK_BITS = $clog2(ENTRIES);
   localparam int CNT_BITS  = $clog2(ENTRIES + 1);
   localparam int CAP_BITS  = 5;
   localparam int CMP_BITS  = (CNT_BITS > CAP_BITS) ? CNT_BITS : CAP_BITS;

   localparam logic [CAP_BITS-1:0] CAP_RESET = CAP_BITS'(16);

   typedef enum logic {
      ACT_GET = 1'b0,
      ACT_PUT = 1'b1
   } action_type;

   typedef struct packed {
      action_type           action;
      logic [KEY_BITS-1:0]  lookup_key;
      logic [DATA_BITS-1:0] write_value;
   } item_type;

   typedef struct packed {
      logic                 found;
      logic [DATA_BITS-1:0] read_value;
   } result_type;

endpackage

>>> rtl/lkvc_store.sv
`timescale 1ns / 1ps
module lkvc_store
   import lkvc_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic [CAP_BITS-1:0] capacity,
   input  logic                fire,
   input  item_type            item,
   output result_type          result
);

   logic [KEY_BITS-1:0]  key_ff   [ENTRIES];
   logic [DATA_BITS-1:0] data_ff  [ENTRIES];
   logic [RANK_BITS-1:0] rank_ff  [ENTRIES];
   logic [RANK_BITS-1:0] rank_in  [ENTRIES];
   logic [ENTRIES-1:0]   valid_ff;
   logic [ENTRIES-1:0]   valid_in;
   logic [CNT_BITS-1:0]  count_ff;
   logic [CNT_BITS-1:0]  count_in;

   logic [ENTRIES-1:0]   match;
   logic [ENTRIES-1:0]   free;
   logic [ENTRIES-1:0]   victim;
   logic [ENTRIES-1:0]   hit_oh;
   logic [ENTRIES-1:0]   free_oh;
   logic [ENTRIES-1:0]   slot_oh;
   logic [ENTRIES-1:0]   key_we;
   logic [ENTRIES-1:0]   data_we;
   logic [RANK_BITS-1:0] hit_rank;
   logic [RANK_BITS-1:0] last_rank;
   logic [DATA_BITS-1:0] hit_data;
   logic [CMP_BITS-1:0]  cap_eff;
   logic [CMP_BITS-1:0]  count_wide;
   logic                 hit;
   logic                 is_put;
   logic                 insert;
   logic                 evict;

   assign is_put     = (item.action == ACT_PUT);
   // oldest valid entry carries rank count-1; only used when count is nonzero
   assign last_rank  = RANK_BITS'(count_ff - CNT_BITS'(1));
   assign count_wide = CMP_BITS'(count_ff);

   always_comb begin
      cap_eff = CMP_BITS'(capacity);
      if (capacity == '0) begin
         cap_eff = CMP_BITS'(1);
      end else if (CMP_BITS'(capacity) > CMP_BITS'(ENTRIES)) begin
         cap_eff = CMP_BITS'(ENTRIES);
      end
   end

   always_comb begin
      for (int i = 0; i < ENTRIES; i++) begin
         match[i]  = valid_ff[i] && (key_ff[i] == item.lookup_key);
         free[i]   = !valid_ff[i];
         victim[i] = valid_ff[i] && (rank_ff[i] == last_rank);
      end
   end

   // isolate the lowest set bit
   assign hit_oh  = match & (~match + ENTRIES'(1));
   assign free_oh = free & (~free + ENTRIES'(1));
   assign hit     = |match;
   assign insert  = is_put && !hit;
   assign evict   = insert && ((count_wide >= cap_eff) || !(|free));
   assign slot_oh = evict ? victim : free_oh;

   always_comb begin
      hit_rank = '0;
      hit_data = '0;
      for (int i = 0; i < ENTRIES; i++) begin
         hit_rank = hit_rank | (hit_oh[i] ? rank_ff[i] : '0);
         hit_data = hit_data | (hit_oh[i] ? data_ff[i] : '0);
      end
   end

   always_comb begin
      for (int i = 0; i < ENTRIES; i++) begin
         key_we[i]   = fire && insert && slot_oh[i];
         data_we[i]  = fire && is_put && (hit ? hit_oh[i] : slot_oh[i]);
         valid_in[i] = valid_ff[i] || (fire && insert && slot_oh[i]);
         rank_in[i]  = rank_ff[i];
         if (fire && hit) begin
            if (hit_oh[i]) begin
               rank_in[i] = '0;
            end else if (valid_ff[i] && (rank_ff[i] < hit_rank)) begin
               rank_in[i] = rank_ff[i] + RANK_BITS'(1);
            end
         end else if (fire && insert) begin
            if (slot_oh[i]) begin
               rank_in[i] = '0;
            end else if (valid_ff[i]) begin
               rank_in[i] = rank_ff[i] + RANK_BITS'(1);
            end
         end
      end
      count_in = count_ff;
      if (fire && insert && !evict) begin
         count_in = count_ff + CNT_BITS'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         count_ff <= '0;
         for (int i = 0; i < ENTRIES; i++) begin
            rank_ff[i] <= '0;
         end
      end else begin
         valid_ff <= valid_in;
         count_ff <= count_in;
         for (int i = 0; i < ENTRIES; i++) begin
            rank_ff[i] <= rank_in[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < ENTRIES; i++) begin
         if (key_we[i]) begin
            key_ff[i] <= item.lookup_key;
         end
         if (data_we[i]) begin
            data_ff[i] <= item.write_value;
         end
      end
   end

   assign result.found      = hit;
   assign result.read_value = (hit && !is_put) ? hit_data : '0;

endmodule

>>> rtl/lru_key_value_cache_core.sv
`timescale 1ns / 1ps
// Fully associative key/value cache with least-recently-used replacement.
// Request words carry a get or put (req_tuser) plus key and value (req_tdata).
// Every request yields exactly one response word: rsp_tuser is the hit flag,
// rsp_tdata the stored value on a get hit and zero otherwise.
// A put on a new key evicts the least recent entry once the number of valid
// entries reaches csr_wdata as last written (0 acts as 1, above 16 as 16).
// Write csr only while no request is in flight.
// Each request passes through one input register and one response register.
// Throughput: one word per cycle while rsp_tready stays high; the
// 16-way parallel key compare and rank update are combinational.
// Reset clears all valid marks and ranks, sets capacity to 16 and empties
// both registers; keys and values need no clearing.
// When rsp_tready is low the response holds, the input register keeps its
// word and req_tready drops once both are occupied; nothing is lost.
module lru_key_value_cache_core
   import lkvc_pkg::*;
(
   input  logic                clock,
   input  logic                reset,

   input  logic                req_tvalid,
   output logic                req_tready,
   input  logic [63:0]         req_tdata,   // [31:0] lookup_key, [63:32] write_value
   input  logic                req_tuser,   // [0] action

   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   output logic [31:0]         rsp_tdata,   // [31:0] read_value
   output logic                rsp_tuser,   // [0] found

   input  logic                csr_wen,
   input  logic [CAP_BITS-1:0] csr_wdata
);

   logic                 in_vld_ff;
   item_type             item_ff;
   logic                 out_vld_ff;
   result_type           out_ff;
   logic [CAP_BITS-1:0]  cap_ff;
   result_type           result;
   logic                 out_free;
   logic                 fire;

   assign out_free   = !out_vld_ff || rsp_tready;
   assign fire       = in_vld_ff && out_free;
   assign req_tready = !in_vld_ff || out_free;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff  <= 1'b0;
         out_vld_ff <= 1'b0;
         cap_ff     <= CAP_RESET;
      end else begin
         if (req_tready) begin
            in_vld_ff <= req_tvalid;
         end
         if (out_free) begin
            out_vld_ff <= in_vld_ff;
         end
         if (csr_wen) begin
            cap_ff <= csr_wdata;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         item_ff.action      <= action_type'(req_tuser);
         item_ff.lookup_key  <= req_tdata[KEY_BITS-1:0];
         item_ff.write_value <= req_tdata[32 +: DATA_BITS];
      end
      if (fire) begin
         out_ff <= result;
      end
   end

   lkvc_store u_store (
      .clock    (clock),
      .reset    (reset),
      .capacity (cap_ff),
      .fire     (fire),
      .item     (item_ff),
      .result   (result)
   );

   assign rsp_tvalid = out_vld_ff;
   assign rsp_tdata  = out_ff.read_value;
   assign rsp_tuser  = out_ff.found;

endmodule

>>> tb/testbench.sv
`timescale 1ns / 1ps
module testbench;
   import lkvc_pkg::*;

   localparam int HOLD_CYCLES = 400;
   localparam int CYCLE_LIMIT = 400000;
   localparam int PHASE_WORDS = 125;
   localparam int PHASES      = 10;

   logic                clock      = 1'b0;
   logic                reset      = 1'b1;
   logic                req_tvalid = 1'b0;
   logic                req_tready;
   logic [63:0]         req_tdata  = '0;
   logic                req_tuser  = 1'b0;
   logic                rsp_tvalid;
   logic                rsp_tready = 1'b0;
   logic [31:0]         rsp_tdata;
   logic                rsp_tuser;
   logic                csr_wen    = 1'b0;
   logic [CAP_BITS-1:0] csr_wdata  = '0;

   lru_key_value_cache_core uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_wen    (csr_wen),
      .csr_wdata  (csr_wdata)
   );

   always begin
      clock = 1'b1;
      #10;
      clock = 1'b0;
      #10;
   end

   // Shadow copy of the cache contents and recency order.
   logic [KEY_BITS-1:0]  cache_key   [ENTRIES];
   logic [DATA_BITS-1:0] cache_data  [ENTRIES];
   bit                   cache_valid [ENTRIES] = '{default: 1'b0};
   int                   cache_rank  [ENTRIES] = '{default: 0};
   int                   cache_count    = 0;
   logic [CAP_BITS-1:0]  cache_capacity = CAP_RESET;

   item_type   pending_words    [$];
   result_type expected_results [$];

   logic [CAP_BITS-1:0] capacity_plan [PHASES] = '{
      CAP_BITS'(4), CAP_BITS'(0), CAP_BITS'(1), CAP_BITS'(31), CAP_BITS'(17),
      CAP_BITS'(16), CAP_BITS'(2), CAP_BITS'(9), CAP_BITS'(3), CAP_BITS'(16)
   };

   bit          req_taken      = 1'b0;
   bit          rsp_taken      = 1'b0;
   bit          quiet_sender   = 1'b0;
   bit          quiet_receiver = 1'b0;
   bit          hold_armed     = 1'b0;
   int          hold_count     = 0;
   int unsigned send_gap       = 0;
   int unsigned recv_gap       = 0;
   int          cycle_count    = 0;
   int          fail_count     = 0;

   function automatic int unsigned draw_gap(bit quiet);
      return quiet ? 0 : $urandom_range(0, 16);
   endfunction

   // Age valid entries more recent than limit, then put slot s at the front.
   function automatic void make_newest(int s, int limit);
      for (int i = 0; i < ENTRIES; i++) begin
         if (cache_valid[i] && i != s && cache_rank[i] < limit) begin
            cache_rank[i] = cache_rank[i] + 1;
         end
      end
      cache_rank[s] = 0;
   endfunction

   function automatic result_type predict_access(item_type w);
      result_type r;
      int         hit;
      int         slot;
      int         victim;
      int         cap;
      hit          = -1;
      slot         = -1;
      victim       = -1;
      r.found      = 1'b0;
      r.read_value = '0;
      for (int i = ENTRIES - 1; i >= 0; i--) begin
         if (cache_valid[i] && cache_key[i] == w.lookup_key) begin
            hit = i;
         end
      end
      if (hit >= 0) begin
         r.found = 1'b1;
         make_newest(hit, cache_rank[hit]);
         if (w.action == ACT_PUT) begin
            cache_data[hit] = w.write_value;
         end else begin
            r.read_value = cache_data[hit];
         end
         return r;
      end
      if (w.action == ACT_GET) begin
         return r;
      end
      for (int i = ENTRIES - 1; i >= 0; i--) begin
         if (!cache_valid[i]) begin
            slot = i;
         end
      end
      cap = int'(cache_capacity);
      if (cap < 1) cap = 1;
      if (cap > ENTRIES) cap = ENTRIES;
      if (cache_count >= cap || slot < 0) begin
         for (int i = 0; i < ENTRIES; i++) begin
            if (cache_valid[i] && (victim < 0 || cache_rank[i] > cache_rank[victim])) begin
               victim = i;
            end
         end
         if (victim >= 0) begin
            cache_valid[victim] = 1'b0;
            if (cache_count > 0) cache_count = cache_count - 1;
            slot = victim;
         end
      end
      if (slot >= 0) begin
         cache_key[slot]   = w.lookup_key;
         cache_data[slot]  = w.write_value;
         cache_valid[slot] = 1'b1;
         make_newest(slot, ENTRIES + 1);
         cache_count = cache_count + 1;
      end
      return r;
   endfunction

   task automatic queue_word(action_type a, logic [31:0] k, logic [31:0] v);
      item_type w;
      w.action      = a;
      w.lookup_key  = k;
      w.write_value = v;
      pending_words.push_back(w);
   endtask

   // Mostly keys from a small pool so gets hit and puts update or evict.
   task automatic queue_random_phase(int n);
      logic [31:0] key_pool [40];
      int          pool_size;
      int          sel;
      logic [31:0] k;
      logic [31:0] v;
      pool_size = $urandom_range(2, 40);
      for (int i = 0; i < 40; i++) begin
         key_pool[i] = $urandom;
      end
      for (int i = 0; i < n; i++) begin
         sel = $urandom_range(0, 19);
         case (sel)
            0: k = $urandom;
            1: k = '0;
            2: k = '1;
            default: k = key_pool[$urandom_range(0, pool_size - 1)];
         endcase
         sel = $urandom_range(0, 15);
         v = (sel == 0) ? '0 : (sel == 1) ? '1 : $urandom;
         queue_word($urandom_range(0, 1) ? ACT_PUT : ACT_GET, k, v);
      end
   endtask

   task automatic wait_idle();
      while (pending_words.size() != 0 || req_tvalid || expected_results.size() != 0) begin
         @(posedge clock);
      end
      repeat (4) @(posedge clock);
   endtask

   task automatic write_capacity(logic [CAP_BITS-1:0] v);
      @(negedge clock);
      csr_wen   <= 1'b1;
      csr_wdata <= v;
      @(negedge clock);
      csr_wen   <= 1'b0;
      cache_capacity = v;
   endtask

   // Sender: present a word, hold it until taken, then idle for the drawn gap.
   always @(negedge clock) begin
      item_type next_word;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || req_taken) begin
         if (send_gap > 0) begin
            send_gap   <= send_gap - 1;
            req_tvalid <= 1'b0;
         end else if (pending_words.size() != 0) begin
            next_word = pending_words.pop_front();
            req_tvalid <= 1'b1;
            req_tdata  <= {next_word.write_value, next_word.lookup_key};
            req_tuser  <= next_word.action;
            send_gap   <= draw_gap(quiet_sender);
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // Long back-pressure stretch, armed once.
   always @(posedge clock) begin
      if (hold_armed && hold_count < HOLD_CYCLES) begin
         hold_count <= hold_count + 1;
      end
   end

   always @(negedge clock) begin
      int unsigned wait_left;
      if (reset) begin
         rsp_tready <= 1'b0;
         recv_gap   <= 0;
      end else begin
         if (rsp_taken) begin
            wait_left = draw_gap(quiet_receiver);
         end else begin
            wait_left = (recv_gap > 0) ? recv_gap - 1 : 0;
         end
         recv_gap   <= wait_left;
         rsp_tready <= (wait_left == 0) && !(hold_armed && hold_count < HOLD_CYCLES);
      end
   end

   always @(posedge clock) begin
      item_type   seen;
      result_type want;
      if (reset) begin
         req_taken <= 1'b0;
         rsp_taken <= 1'b0;
      end else if (cycle_count >= CYCLE_LIMIT) begin
         $display("lru_key_value_cache_core regression: fail");
         $finish;
      end else begin
         cycle_count = cycle_count + 1;
         req_taken <= req_tvalid && req_tready;
         rsp_taken <= rsp_tvalid && rsp_tready;
         if (req_tvalid && req_tready) begin
            seen.action      = action_type'(req_tuser);
            seen.lookup_key  = req_tdata[31:0];
            seen.write_value = req_tdata[63:32];
            expected_results.push_back(predict_access(seen));
         end
         if (rsp_tvalid && rsp_tready) begin
            if (expected_results.size() == 0) begin
               fail_count = fail_count + 1;
               if (fail_count <= 10) begin
                  $display("%0t: unexpected word found=%0b value=%h",
                           $realtime, rsp_tuser, rsp_tdata);
               end
            end else begin
               want = expected_results.pop_front();
               if (rsp_tuser !== want.found || rsp_tdata !== want.read_value) begin
                  fail_count = fail_count + 1;
                  if (fail_count <= 10) begin
                     $display("%0t: mismatch found exp=%0b got=%0b value exp=%h got=%h",
                              $realtime, want.found, rsp_tuser, want.read_value, rsp_tdata);
                  end
               end
            end
         end
      end
   end

   initial begin
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Empty cache, extreme keys and values, update in place, then fill past 16.
      queue_word(ACT_GET, 32'h0000_0000, 32'hFFFF_FFFF);
      queue_word(ACT_PUT, 32'h0000_0000, 32'hFFFF_FFFF);
      queue_word(ACT_GET, 32'h0000_0000, 32'h0000_0000);
      queue_word(ACT_PUT, 32'hFFFF_FFFF, 32'h0000_0000);
      queue_word(ACT_GET, 32'hFFFF_FFFF, 32'hA5A5_A5A5);
      queue_word(ACT_PUT, 32'h0000_0000, 32'h1234_5678);
      queue_word(ACT_GET, 32'h0000_0000, 32'h0000_0000);
      for (int i = 1; i <= 16; i++) begin
         queue_word(ACT_PUT, 32'(i), ~32'(i));
      end
      queue_word(ACT_GET, 32'hFFFF_FFFF, 32'h0000_0000);
      queue_word(ACT_GET, 32'h0000_0010, 32'h0000_0000);

      // The first write lowers capacity below a full cache.
      for (int p = 0; p < PHASES; p++) begin
         wait_idle();
         write_capacity(capacity_plan[p]);
         @(posedge clock);
         quiet_sender   <= (p % 3 == 1) || (p == 3);
         quiet_receiver <= (p % 4 == 2);
         if (p == 3) begin
            hold_armed <= 1'b1;
         end
         queue_random_phase(PHASE_WORDS);
      end

      wait_idle();
      repeat (8) @(posedge clock);
      if (fail_count == 0 && expected_results.size() == 0) begin
         $display("lru_key_value_cache_core regression: pass");
      end else begin
         $display("lru_key_value_cache_core regression: fail");
      end
      $finish;
   end

endmodule
